### sv/tsla_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the texture lock address block.
// No dependencies; every other file imports this package.
package tsla_pkg;

  localparam int DIM_W     = 13;
  localparam int LVL_W     = 4;
  localparam int FACE_W    = 3;
  localparam int FMT_W     = 2;
  localparam int ADDR_W    = 32;
  localparam int PITCH_W   = 15;
  localparam int SIZE_W    = 27;
  localparam int STAT_W    = 2;
  localparam int CHAIN_W   = 27;
  localparam int SHIFT_W   = 3;
  localparam int REG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int SUBRES_W  = 7;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_SUB  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_RECT = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISALIGN = 2'd3;

  localparam logic [FMT_W-1:0] FMT_PIX32 = 2'd0;
  localparam logic [FMT_W-1:0] FMT_BLK8  = 2'd1;

  // Byte scale as a shift: 4-byte pixels, 8-byte blocks, 16-byte blocks.
  localparam logic [SHIFT_W-1:0] SHIFT_PIX   = 3'd2;
  localparam logic [SHIFT_W-1:0] SHIFT_BLK8  = 3'd3;
  localparam logic [SHIFT_W-1:0] SHIFT_BLK16 = 3'd4;

  localparam logic [FACE_W-1:0] MAX_FACES = 3'd6;

  localparam logic [REG_IDX_W-1:0] REG_TEX_WIDTH    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TEX_HEIGHT   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MIP_LEVELS   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FACE_COUNT   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_STAGING_BASE = 3'd5;

  typedef struct packed {
    logic [DIM_W-1:0]  tex_width;
    logic [DIM_W-1:0]  tex_height;
    logic [LVL_W-1:0]  mip_levels;
    logic [FACE_W-1:0] face_count;
    logic [FMT_W-1:0]  pixel_format;
    logic [ADDR_W-1:0] staging_base;
  } tsla_cfg_t;

  // Texture geometry as the request pipeline sees it.
  typedef struct packed {
    logic [DIM_W-1:0]   eff_width;
    logic [DIM_W-1:0]   eff_height;
    logic [LVL_W-1:0]   levels;
    logic [FACE_W-1:0]  faces;
    logic               is_block;
    logic [SHIFT_W-1:0] unit_shift;
    logic [ADDR_W-1:0]  base;
    logic [CHAIN_W-1:0] face_chain;
  } tsla_geom_t;

  function automatic logic [DIM_W-1:0] level_dim(input logic [DIM_W-1:0] d,
                                                 input logic [LVL_W-1:0] lvl);
    logic [DIM_W-1:0] v;
    v = d >> lvl;
    return (v == '0) ? DIM_W'(1) : v;
  endfunction

  // Number of 4x4 blocks that cover a dimension.
  function automatic logic [DIM_W-1:0] block_count(input logic [DIM_W-1:0] d);
    logic [DIM_W:0] t;
    t = {1'b0, d} + (DIM_W+1)'(3);
    return DIM_W'(t >> 2);
  endfunction

  function automatic logic [LVL_W-1:0] bit_length(input logic [DIM_W-1:0] v);
    logic [LVL_W-1:0] n;
    n = '0;
    for (int i = 0; i < DIM_W; i++) begin
      if (v[i]) n = LVL_W'(i + 1);
    end
    return n;
  endfunction

endpackage

### sv/tsla_chain.sv
`timescale 1ns / 1ps
// Geometry decode and mip chain sweep: builds the table of per-level start offsets.
// Depends on tsla_pkg.
module tsla_chain import tsla_pkg::*; #(
  parameter int MAX_DIM    = 4096,
  parameter int MAX_LEVELS = 13
) (
  input  logic              clk,
  input  logic              rst,
  input  tsla_cfg_t         cfg,
  input  logic              restart,
  input  logic [LVL_W-1:0]  rd_level,
  output logic [ADDR_W-1:0] rd_prefix,
  output tsla_geom_t        geom,
  output logic              busy
);

  localparam int DEPTH = MAX_LEVELS + 1;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int PROD_W = 2 * DIM_W;

  localparam logic [1:0] SW_IDLE   = 2'd0;
  localparam logic [1:0] SW_SETTLE = 2'd1;
  localparam logic [1:0] SW_RUN    = 2'd2;
  localparam logic [1:0] SW_DRAIN  = 2'd3;

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic [IDX_W-1:0]   idx;
  logic               prod_valid;
  logic [IDX_W-1:0]   prod_idx;
  logic [PROD_W-1:0]  prod;
  logic [ADDR_W-1:0]  acc;
  logic [ADDR_W-1:0]  acc_next;
  logic [IDX_W-1:0]   wr_idx;
  logic [ADDR_W-1:0]  prefix [DEPTH];
  logic [CHAIN_W-1:0] face_chain;
  logic [IDX_W-1:0]   rd_idx;

  logic [DIM_W-1:0]   w_eff;
  logic [DIM_W-1:0]   h_eff;
  logic [LVL_W-1:0]   lev_eff;
  logic [DIM_W-1:0]   lw;
  logic [DIM_W-1:0]   lh;
  logic [DIM_W-1:0]   ua;
  logic [DIM_W-1:0]   ub;

  logic [DIM_W-1:0]   shape_w;
  logic [DIM_W-1:0]   shape_h;
  logic [LVL_W-1:0]   shape_lev;
  logic [FACE_W-1:0]  shape_faces;
  logic               shape_blk;
  logic [SHIFT_W-1:0] shape_shift;

  // Clamp the configured sizes and counts.
  always_comb begin
    if (cfg.tex_width == '0) w_eff = DIM_W'(1);
    else if (32'(cfg.tex_width) > MAX_DIM) w_eff = DIM_W'(MAX_DIM);
    else w_eff = cfg.tex_width;
    if (cfg.tex_height == '0) h_eff = DIM_W'(1);
    else if (32'(cfg.tex_height) > MAX_DIM) h_eff = DIM_W'(MAX_DIM);
    else h_eff = cfg.tex_height;
    lev_eff = (cfg.mip_levels == '0) ? bit_length(w_eff | h_eff) : cfg.mip_levels;
    if (32'(lev_eff) > MAX_LEVELS) lev_eff = LVL_W'(MAX_LEVELS);
  end

  always_ff @(posedge clk) begin
    shape_w     <= w_eff;
    shape_h     <= h_eff;
    shape_lev   <= lev_eff;
    shape_faces <= (cfg.face_count > MAX_FACES) ? MAX_FACES : cfg.face_count;
    shape_blk   <= (cfg.pixel_format != FMT_PIX32);
    if (cfg.pixel_format == FMT_PIX32) shape_shift <= SHIFT_PIX;
    else if (cfg.pixel_format == FMT_BLK8) shape_shift <= SHIFT_BLK8;
    else shape_shift <= SHIFT_BLK16;
  end

  always_comb begin
    geom.eff_width  = shape_w;
    geom.eff_height = shape_h;
    geom.levels     = shape_lev;
    geom.faces      = shape_faces;
    geom.is_block   = shape_blk;
    geom.unit_shift = shape_shift;
    geom.base       = cfg.staging_base;
    geom.face_chain = face_chain;
  end

  assign busy = (state != SW_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      SW_IDLE:   state_next = SW_IDLE;
      SW_SETTLE: state_next = SW_RUN;
      SW_RUN:    if (idx == IDX_W'(MAX_LEVELS - 1)) state_next = SW_DRAIN;
      SW_DRAIN:  state_next = SW_IDLE;
      default:   state_next = SW_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= SW_SETTLE;
    end else begin
      state <= state_next;
    end
  end

  // Size of the level under the sweep counter, in pixels or blocks.
  always_comb begin
    lw = level_dim(shape_w, LVL_W'(idx));
    lh = level_dim(shape_h, LVL_W'(idx));
    ua = shape_blk ? block_count(lw) : lw;
    ub = shape_blk ? block_count(lh) : lh;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= (state == SW_RUN);
    end
    prod     <= ua * ub;
    prod_idx <= idx;
    if (state == SW_RUN) begin
      idx <= idx + IDX_W'(1);
    end else begin
      idx <= '0;
    end
  end

  always_comb begin
    acc_next = acc + ADDR_W'({{SHIFT_W{1'b0}}, prod} << shape_shift);
    wr_idx   = IDX_W'({1'b0, prod_idx} + (IDX_W+1)'(1));
  end

  // Running sum of level sizes; entry i holds the bytes of all levels below i.
  always_ff @(posedge clk) begin
    if (state == SW_SETTLE) begin
      acc       <= '0;
      prefix[0] <= '0;
    end else if (prod_valid) begin
      acc            <= acc_next;
      prefix[wr_idx] <= acc_next;
      if (LVL_W'(wr_idx) == shape_lev) face_chain <= acc_next[CHAIN_W-1:0];
    end
  end

  assign rd_idx = (32'(rd_level) < DEPTH) ? rd_level[IDX_W-1:0] : '0;

  always_ff @(posedge clk) begin
    rd_prefix <= prefix[rd_idx];
  end

endmodule

### sv/tsla_pipe.sv
`timescale 1ns / 1ps
// Four-stage request pipeline: level decode, checks and products, rectangle offset, result.
// Depends on tsla_pkg; level start offsets come from tsla_chain.
module tsla_pipe import tsla_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  tsla_geom_t          geom,
  input  logic [FACE_W-1:0]   face_index,
  input  logic [LVL_W-1:0]    level_index,
  input  logic                has_rect,
  input  logic [DIM_W-1:0]    rect_left,
  input  logic [DIM_W-1:0]    rect_top,
  input  logic [DIM_W-1:0]    rect_right,
  input  logic [DIM_W-1:0]    rect_bottom,
  input  logic [ADDR_W-1:0]   level_prefix,
  output logic                done,
  output logic [STAT_W-1:0]   status,
  output logic [PITCH_W-1:0]  row_pitch_bytes,
  output logic [ADDR_W-1:0]   lock_address,
  output logic [DIM_W-1:0]    level_width,
  output logic [DIM_W-1:0]    level_height,
  output logic [SIZE_W-1:0]   level_size_bytes
);

  localparam int PROD_W = 2 * DIM_W;
  localparam int FOFF_W = CHAIN_W + FACE_W;
  localparam int ROFF_W = 30;
  localparam int FULL_SIZE_W = 28;

  // Stage 1
  logic                v1;
  logic                bad1;
  logic [FACE_W-1:0]   face1;
  logic [LVL_W-1:0]    lvl1;
  logic                hr1;
  logic [DIM_W-1:0]    left1, top1, right1, bottom1;
  logic [DIM_W-1:0]    lw1, lh1;
  logic [FOFF_W-1:0]   foff1;

  // Stage 2
  logic                v2;
  logic                bad2;
  logic [STAT_W-1:0]   st2;
  logic                use_off2;
  logic [DIM_W-1:0]    lw2, lh2;
  logic [PITCH_W:0]    pitch2;
  logic [PROD_W-1:0]   prod2;
  logic [ADDR_W-1:0]   laddr2;
  logic [DIM_W-1:0]    row2;
  logic [PITCH_W-1:0]  col2;
  logic [SUBRES_W-1:0] held2;

  // Stage 3
  logic                v3;
  logic                bad3;
  logic [STAT_W-1:0]   st3;
  logic                use_off3;
  logic [DIM_W-1:0]    lw3, lh3;
  logic [PITCH_W:0]    pitch3;
  logic [FULL_SIZE_W-1:0] size3;
  logic [ADDR_W-1:0]   laddr3;
  logic [ROFF_W-1:0]   roff3;
  logic [SUBRES_W-1:0] held3;

  // Lock state
  logic                lock_held;
  logic [SUBRES_W-1:0] held_subresource;

  // Stage 1 combinational terms
  logic [DIM_W-1:0]    a1, b1;
  logic [STAT_W-1:0]   st1;
  logic [DIM_W-1:0]    colu1;
  logic [PITCH_W:0]    colx1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    bad1    <= (level_index >= geom.levels) || (face_index >= geom.faces);
    face1   <= face_index;
    lvl1    <= level_index;
    hr1     <= has_rect;
    left1   <= rect_left;
    top1    <= rect_top;
    right1  <= rect_right;
    bottom1 <= rect_bottom;
    lw1     <= level_dim(geom.eff_width, level_index);
    lh1     <= level_dim(geom.eff_height, level_index);
    foff1   <= FOFF_W'(face_index) * FOFF_W'(geom.face_chain);
  end

  always_comb begin
    a1 = geom.is_block ? block_count(lw1) : lw1;
    b1 = geom.is_block ? block_count(lh1) : lh1;
    if (bad1) begin
      st1 = ST_BAD_SUB;
    end else if (!hr1) begin
      st1 = ST_OK;
    end else if (right1 <= left1 || bottom1 <= top1 || right1 > lw1 || bottom1 > lh1) begin
      st1 = ST_BAD_RECT;
    end else if (geom.is_block && (left1[1:0] != 2'b00 || top1[1:0] != 2'b00)) begin
      st1 = ST_MISALIGN;
    end else begin
      st1 = ST_OK;
    end
    colu1 = geom.is_block ? (left1 >> 2) : left1;
    colx1 = (PITCH_W+1)'(colu1) << geom.unit_shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    bad2     <= bad1;
    st2      <= st1;
    use_off2 <= hr1 && (st1 == ST_OK);
    lw2      <= lw1;
    lh2      <= lh1;
    pitch2   <= (PITCH_W+1)'(a1) << geom.unit_shift;
    prod2    <= a1 * b1;
    laddr2   <= geom.base + ADDR_W'(foff1) + level_prefix;
    row2     <= geom.is_block ? (top1 >> 2) : top1;
    col2     <= colx1[PITCH_W-1:0];
    held2    <= SUBRES_W'(FACE_W'(face1) * geom.levels + {4'b0, lvl1});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    bad3     <= bad2;
    st3      <= st2;
    use_off3 <= use_off2;
    lw3      <= lw2;
    lh3      <= lh2;
    pitch3   <= pitch2;
    size3    <= FULL_SIZE_W'({2'b00, prod2} << geom.unit_shift);
    laddr3   <= laddr2;
    roff3    <= ROFF_W'(row2) * ROFF_W'(pitch2) + ROFF_W'(col2);
    held3    <= held2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done             <= 1'b0;
      lock_held        <= 1'b0;
      held_subresource <= '0;
    end else begin
      done <= v3;
      if (v3 && st3 == ST_OK) begin
        lock_held        <= 1'b1;
        held_subresource <= held3;
      end
    end
    status <= st3;
    if (bad3) begin
      row_pitch_bytes  <= '0;
      lock_address     <= '0;
      level_width      <= '0;
      level_height     <= '0;
      level_size_bytes <= '0;
    end else begin
      row_pitch_bytes  <= pitch3[PITCH_W-1:0];
      lock_address     <= laddr3 + (use_off3 ? ADDR_W'(roff3) : '0);
      level_width      <= lw3;
      level_height     <= lh3;
      level_size_bytes <= size3[SIZE_W-1:0];
    end
  end

endmodule

### sv/texture_subresource_lock_address_top.sv
`timescale 1ns / 1ps
// Texture sub-resource lock address unit: top level with the configuration registers.
// Depends on tsla_pkg, tsla_chain and tsla_pipe.
//
// Each accepted item comes out as one done pulse at the end of the request pipeline.
// Throughput: one item per cycle whenever busy is low; results cannot be stalled.
// Reset (synchronous, active high) restores the default registers and then runs a
// sweep that fills the level offset table; busy is high for that sweep, and the
// same sweep follows every register write.
module texture_subresource_lock_address_top import tsla_pkg::*; #(
  parameter int MAX_DIM    = 4096,
  parameter int MAX_LEVELS = 13
) (
  input  logic                 clk,
  input  logic                 rst,
  // Request channel
  input  logic                 start,
  output logic                 busy,
  input  logic [FACE_W-1:0]    face_index,
  input  logic [LVL_W-1:0]     level_index,
  input  logic                 has_rect,
  input  logic [DIM_W-1:0]     rect_left,
  input  logic [DIM_W-1:0]     rect_top,
  input  logic [DIM_W-1:0]     rect_right,
  input  logic [DIM_W-1:0]     rect_bottom,
  // Result channel
  output logic                 done,
  output logic [STAT_W-1:0]    status,
  output logic [PITCH_W-1:0]   row_pitch_bytes,
  output logic [ADDR_W-1:0]    lock_address,
  output logic [DIM_W-1:0]     level_width,
  output logic [DIM_W-1:0]     level_height,
  output logic [SIZE_W-1:0]    level_size_bytes,
  // Configuration write port
  input  logic                 cfg_write,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  tsla_cfg_t         cfg;
  tsla_geom_t        geom;
  logic              restart;
  logic              accept;
  logic [ADDR_W-1:0] level_prefix;

  // A write to any known register restarts the level table sweep; writes past
  // the last register are dropped.
  assign restart = cfg_write && (cfg_index <= REG_STAGING_BASE);

  // An item is taken whenever start is high and no sweep is running.
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tex_width    <= DIM_W'(1);
      cfg.tex_height   <= DIM_W'(1);
      cfg.mip_levels   <= LVL_W'(1);
      cfg.face_count   <= FACE_W'(1);
      cfg.pixel_format <= FMT_PIX32;
      cfg.staging_base <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TEX_WIDTH:    cfg.tex_width    <= cfg_data[DIM_W-1:0];
        REG_TEX_HEIGHT:   cfg.tex_height   <= cfg_data[DIM_W-1:0];
        REG_MIP_LEVELS:   cfg.mip_levels   <= cfg_data[LVL_W-1:0];
        REG_FACE_COUNT:   cfg.face_count   <= cfg_data[FACE_W-1:0];
        REG_PIXEL_FORMAT: cfg.pixel_format <= cfg_data[FMT_W-1:0];
        REG_STAGING_BASE: cfg.staging_base <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // The chain unit clamps the geometry and holds, for every level, the byte
  // offset of that level inside one face, plus the size of a whole face.
  tsla_chain #(
    .MAX_DIM    (MAX_DIM),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_chain (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .restart   (restart),
    .rd_level  (level_index),
    .rd_prefix (level_prefix),
    .geom      (geom),
    .busy      (busy)
  );

  // The request pipeline checks the item, forms the level dimensions, pitch
  // and size, and adds the face, level and rectangle offsets to the base.
  tsla_pipe u_pipe (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .geom             (geom),
    .face_index       (face_index),
    .level_index      (level_index),
    .has_rect         (has_rect),
    .rect_left        (rect_left),
    .rect_top         (rect_top),
    .rect_right       (rect_right),
    .rect_bottom      (rect_bottom),
    .level_prefix     (level_prefix),
    .done             (done),
    .status           (status),
    .row_pitch_bytes  (row_pitch_bytes),
    .lock_address     (lock_address),
    .level_width      (level_width),
    .level_height     (level_height),
    .level_size_bytes (level_size_bytes)
  );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the texture sub-resource lock address block.
// Depends on tsla_pkg and texture_subresource_lock_address_top; a built-in lock predictor
// supplies the expected result of every request, and each result is checked against it.
module testbench;
  import tsla_pkg::*;

  localparam int unsigned DIM_LIMIT   = 4096;
  localparam int unsigned LEVEL_LIMIT = 13;

  // The package names only the first two format codes and the six live registers.
  localparam logic [FMT_W-1:0]     FMT_BLK16    = 2'd2;
  localparam logic [FMT_W-1:0]     FMT_RESERVED = 2'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPARE    = 3'd6;

  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic [LVL_W-1:0]  level;
    logic              has_rect;
    logic [DIM_W-1:0]  left;
    logic [DIM_W-1:0]  top;
    logic [DIM_W-1:0]  right;
    logic [DIM_W-1:0]  bottom;
  } lock_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [PITCH_W-1:0] pitch;
    logic [ADDR_W-1:0]  addr;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [SIZE_W-1:0]  bytes;
  } lock_result_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [FACE_W-1:0]    face_index;
  logic [LVL_W-1:0]     level_index;
  logic                 has_rect;
  logic [DIM_W-1:0]     rect_left;
  logic [DIM_W-1:0]     rect_top;
  logic [DIM_W-1:0]     rect_right;
  logic [DIM_W-1:0]     rect_bottom;
  logic                 done;
  logic [STAT_W-1:0]    status;
  logic [PITCH_W-1:0]   row_pitch_bytes;
  logic [ADDR_W-1:0]    lock_address;
  logic [DIM_W-1:0]     level_width;
  logic [DIM_W-1:0]     level_height;
  logic [SIZE_W-1:0]    level_size_bytes;
  logic                 cfg_write;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  texture_subresource_lock_address_top #(
    .MAX_DIM(DIM_LIMIT),
    .MAX_LEVELS(LEVEL_LIMIT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .face_index(face_index),
    .level_index(level_index),
    .has_rect(has_rect),
    .rect_left(rect_left),
    .rect_top(rect_top),
    .rect_right(rect_right),
    .rect_bottom(rect_bottom),
    .done(done),
    .status(status),
    .row_pitch_bytes(row_pitch_bytes),
    .lock_address(lock_address),
    .level_width(level_width),
    .level_height(level_height),
    .level_size_bytes(level_size_bytes),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the configuration registers and of the lock state, as the
  // block should hold them after reset.
  logic [DIM_W-1:0]    cfg_width   = 1;
  logic [DIM_W-1:0]    cfg_height  = 1;
  logic [LVL_W-1:0]    cfg_mips    = 1;
  logic [FACE_W-1:0]   cfg_faces   = 1;
  logic [FMT_W-1:0]    cfg_fmt     = FMT_PIX32;
  logic [ADDR_W-1:0]   cfg_base    = '0;
  int unsigned         face_stride = 0;
  logic                lock_held   = 1'b0;
  logic [SUBRES_W-1:0] held_subres = '0;

  lock_result_t expected_locks[$];
  int error_count  = 0;
  int items_sent   = 0;
  int reg_writes   = 0;
  int status_seen[4] = '{0, 0, 0, 0};

  // ---------------------------------------------------------------------------
  // Lock predictor. All byte arithmetic is done in 32 bits so that address sums
  // wrap the same way the hardware does; sizes are cut to 27 bits at the end.
  // ---------------------------------------------------------------------------

  // A size register of zero reads as one, anything above the limit as the limit.
  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM_LIMIT) return DIM_LIMIT;
    return v;
  endfunction

  // Levels in use: a count of zero asks for the full chain down to 1x1, and
  // either way the count saturates at the level limit.
  function automatic int unsigned level_count();
    int unsigned w, h, n;
    w = clamp_dim(cfg_width);
    h = clamp_dim(cfg_height);
    n = cfg_mips;
    if (n == 0) begin
      n = 1;
      while (n < 31 && ((w >> n) != 0 || (h >> n) != 0)) n++;
    end
    if (n > LEVEL_LIMIT) n = LEVEL_LIMIT;
    return n;
  endfunction

  function automatic int unsigned mip_dim(input int unsigned d, input int unsigned lvl);
    int unsigned v;
    v = (lvl < 31) ? (d >> lvl) : 0;
    return (v == 0) ? 1 : v;
  endfunction

  // Zero stands for four-byte pixels; otherwise the bytes of one 4x4 block.
  // The reserved format code behaves like 16-byte blocks.
  function automatic int unsigned unit_bytes();
    if (cfg_fmt == FMT_PIX32) return 0;
    if (cfg_fmt == FMT_BLK8) return 8;
    return 16;
  endfunction

  function automatic int unsigned mip_bytes(input int unsigned w, input int unsigned h);
    int unsigned bb;
    bb = unit_bytes();
    if (bb == 0) return w * h * 4;
    return ((w + 3) / 4) * ((h + 3) / 4) * bb;
  endfunction

  function automatic int unsigned row_bytes(input int unsigned w);
    int unsigned bb;
    bb = unit_bytes();
    if (bb == 0) return w * 4;
    return ((w + 3) / 4) * bb;
  endfunction

  // Bytes of all levels that precede the given one inside one face.
  function automatic int unsigned bytes_before(input int unsigned lvl);
    int unsigned w, h, sum;
    w = clamp_dim(cfg_width);
    h = clamp_dim(cfg_height);
    sum = 0;
    for (int unsigned i = 0; i < lvl; i++)
      sum += mip_bytes(mip_dim(w, i), mip_dim(h, i));
    return sum;
  endfunction

  function automatic lock_result_t predict_lock(input lock_req_t rq);
    lock_result_t r;
    int unsigned  nlev, nface, lw, lh, pitch, addr, bb;
    r = '0;
    nlev  = level_count();
    nface = (cfg_faces > MAX_FACES) ? MAX_FACES : cfg_faces;
    // A face or level outside the texture zeroes every other field.
    if (rq.level >= nlev || rq.face >= nface) begin
      r.status = ST_BAD_SUB;
      return r;
    end
    lw    = mip_dim(clamp_dim(cfg_width), rq.level);
    lh    = mip_dim(clamp_dim(cfg_height), rq.level);
    pitch = row_bytes(lw);
    bb    = unit_bytes();
    addr  = cfg_base + rq.face * face_stride + bytes_before(rq.level);
    r.status = ST_OK;
    // A refused rectangle still reports the level geometry and its first byte.
    if (rq.has_rect) begin
      if (rq.right <= rq.left || rq.bottom <= rq.top || rq.right > lw || rq.bottom > lh)
        r.status = ST_BAD_RECT;
      else if (bb == 0)
        addr += rq.top * pitch + rq.left * 4;
      else if (rq.left[1:0] != 2'b00 || rq.top[1:0] != 2'b00)
        r.status = ST_MISALIGN;
      else
        addr += (rq.top / 4) * pitch + (rq.left / 4) * bb;
    end
    // Only a clean lock takes (or replaces) the held sub-resource.
    if (r.status == ST_OK) begin
      lock_held   = 1'b1;
      held_subres = SUBRES_W'(rq.face * nlev + rq.level);
    end
    r.pitch  = PITCH_W'(pitch);
    r.addr   = addr;
    r.width  = DIM_W'(lw);
    r.height = DIM_W'(lh);
    r.bytes  = SIZE_W'(mip_bytes(lw, lh));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving. Every task is entered right after a rising edge; inputs change by
  // nonblocking assignment so the block sees them at the following edge.
  // ---------------------------------------------------------------------------

  // Writes one register, then waits out the table sweep that each write starts.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);
    case (idx)
      REG_TEX_WIDTH:    cfg_width = data[DIM_W-1:0];
      REG_TEX_HEIGHT:   cfg_height = data[DIM_W-1:0];
      REG_MIP_LEVELS:   cfg_mips = data[LVL_W-1:0];
      REG_FACE_COUNT:   cfg_faces = data[FACE_W-1:0];
      REG_PIXEL_FORMAT: cfg_fmt = data[FMT_W-1:0];
      REG_STAGING_BASE: cfg_base = data;
      default:          return;
    endcase
    face_stride = bytes_before(level_count()) & 32'h07FF_FFFF;
    reg_writes++;
  endtask

  // Writes all six registers. With junk set, the unused upper data bits carry
  // random values that the block has to ignore.
  task automatic apply_setting(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                               input logic [LVL_W-1:0] mips, input logic [FACE_W-1:0] faces,
                               input logic [FMT_W-1:0] fmt, input logic [ADDR_W-1:0] base,
                               input bit junk);
    logic [CFG_W-1:0] pad;
    pad = junk ? CFG_W'($urandom()) : '0;
    write_reg(REG_TEX_WIDTH, {pad[CFG_W-1:DIM_W], w});
    write_reg(REG_TEX_HEIGHT, {pad[CFG_W-1:DIM_W], h});
    write_reg(REG_MIP_LEVELS, {pad[CFG_W-1:LVL_W], mips});
    write_reg(REG_FACE_COUNT, {pad[CFG_W-1:FACE_W], faces});
    write_reg(REG_PIXEL_FORMAT, {pad[CFG_W-1:FMT_W], fmt});
    write_reg(REG_STAGING_BASE, base);
  endtask

  // Presents one lock request and holds it until the block takes it. Start is
  // left high so that a following request goes out back to back.
  task automatic send_request(input lock_req_t rq);
    lock_result_t want;
    face_index  <= rq.face;
    level_index <= rq.level;
    has_rect    <= rq.has_rect;
    rect_left   <= rq.left;
    rect_top    <= rq.top;
    rect_right  <= rq.right;
    rect_bottom <= rq.bottom;
    start       <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = predict_lock(rq);
    expected_locks.push_back(want);
    status_seen[want.status]++;
    items_sent++;
  endtask

  // Sender idles with start low and junk on the request fields.
  task automatic pause_requests(input int unsigned cycles);
    start       <= 1'b0;
    face_index  <= FACE_W'($urandom());
    level_index <= LVL_W'($urandom());
    has_rect    <= 1'($urandom());
    rect_left   <= DIM_W'($urandom());
    rect_top    <= DIM_W'($urandom());
    rect_right  <= DIM_W'($urandom());
    rect_bottom <= DIM_W'($urandom());
    repeat (cycles) @(posedge clk);
  endtask

  // Stops sending and waits until every outstanding lock has been answered.
  task automatic end_burst();
    start <= 1'b0;
    while (expected_locks.size() != 0) @(posedge clk);
  endtask

  function automatic lock_req_t lock_req(input int unsigned face, input int unsigned lvl,
                                         input bit rect, input int unsigned l,
                                         input int unsigned t, input int unsigned r,
                                         input int unsigned b);
    lock_req_t rq;
    rq.face     = FACE_W'(face);
    rq.level    = LVL_W'(lvl);
    rq.has_rect = rect;
    rq.left     = DIM_W'(l);
    rq.top      = DIM_W'(t);
    rq.right    = DIM_W'(r);
    rq.bottom   = DIM_W'(b);
    return rq;
  endfunction

  // Random request: mostly a valid face and level with a rectangle that fits
  // the level (block-aligned for block formats), some with one thing broken,
  // and some pure noise over the full field widths.
  function automatic lock_req_t random_request();
    lock_req_t   rq;
    int unsigned nlev, nface, lw, lh, pick;
    rq.face     = FACE_W'($urandom());
    rq.level    = LVL_W'($urandom());
    rq.has_rect = 1'($urandom());
    rq.left     = DIM_W'($urandom());
    rq.top      = DIM_W'($urandom());
    rq.right    = DIM_W'($urandom());
    rq.bottom   = DIM_W'($urandom());
    nlev  = level_count();
    nface = (cfg_faces > MAX_FACES) ? MAX_FACES : cfg_faces;
    pick  = $urandom_range(0, 99);
    if (pick < 85 && nface != 0) begin
      rq.face     = FACE_W'($urandom_range(0, nface - 1));
      rq.level    = LVL_W'($urandom_range(0, nlev - 1));
      rq.has_rect = ($urandom_range(0, 3) != 0);
      lw = mip_dim(clamp_dim(cfg_width), rq.level);
      lh = mip_dim(clamp_dim(cfg_height), rq.level);
      if (unit_bytes() != 0) begin
        rq.left = DIM_W'(4 * $urandom_range(0, (lw - 1) / 4));
        rq.top  = DIM_W'(4 * $urandom_range(0, (lh - 1) / 4));
      end else begin
        rq.left = DIM_W'($urandom_range(0, lw - 1));
        rq.top  = DIM_W'($urandom_range(0, lh - 1));
      end
      rq.right  = DIM_W'($urandom_range(rq.left + 1, lw));
      rq.bottom = DIM_W'($urandom_range(rq.top + 1, lh));
      if (pick >= 70) begin
        case (pick % 5)
          0: begin rq.has_rect = 1'b1; rq.right = rq.left; end
          1: begin rq.has_rect = 1'b1; rq.bottom = DIM_W'(lh + $urandom_range(1, 3)); end
          2: begin rq.has_rect = 1'b1; rq.left[0] = 1'b1; end
          3: rq.level = LVL_W'($urandom_range(nlev, 15));
          default: rq.face = FACE_W'($urandom_range(nface, 7));
        endcase
      end
    end
    return rq;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every done pulse is matched against the oldest prediction.
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    lock_result_t want;
    if (!rst && done === 1'b1) begin
      if (expected_locks.size() == 0) begin
        $error("lock result arrived with no request outstanding");
        error_count++;
      end else begin
        want = expected_locks.pop_front();
        check_field("status", want.status, status);
        check_field("row_pitch_bytes", want.pitch, row_pitch_bytes);
        check_field("lock_address", want.addr, lock_address);
        check_field("level_width", want.width, level_width);
        check_field("level_height", want.height, level_height);
        check_field("level_size_bytes", want.bytes, level_size_bytes);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers describe a single 1x1 four-byte texture at address zero.
  task automatic test_reset_defaults();
    send_request(lock_req(0, 0, 0, 0, 0, 0, 0));
    send_request(lock_req(0, 0, 1, 0, 0, 1, 1));
    send_request(lock_req(1, 0, 0, 0, 0, 0, 0));
    send_request(lock_req(0, 1, 0, 0, 0, 0, 0));
    // Every field at its top value: face and level are refused first.
    send_request(lock_req(7, 15, 1, 8191, 8191, 8191, 8191));
    end_burst();
  endtask

  // Largest cube with the full chain, and a base near the top of the address
  // space so that the face and level offsets wrap past 2^32.
  task automatic test_pixel_limits();
    apply_setting(4096, 4096, 0, 6, FMT_PIX32, 32'hFFFF_FF00, 1'b0);
    send_request(lock_req(5, 0, 1, 0, 0, 4096, 4096));
    send_request(lock_req(5, 12, 0, 0, 0, 0, 0));
    send_request(lock_req(0, 0, 1, 4095, 4095, 4096, 4096));
    send_request(lock_req(1, 0, 1, 0, 0, 4097, 16));
    send_request(lock_req(2, 1, 1, 10, 0, 10, 5));
    send_request(lock_req(3, 2, 1, 0, 9, 4, 8));
    send_request(lock_req(0, 13, 0, 0, 0, 0, 0));
    send_request(lock_req(6, 0, 0, 0, 0, 0, 0));
    // Locking the same sub-resource twice simply replaces the held lock.
    send_request(lock_req(2, 3, 0, 0, 0, 0, 0));
    send_request(lock_req(2, 3, 0, 0, 0, 0, 0));
    end_burst();
  endtask

  // Block formats on a texture whose sides are not multiples of four, so
  // that block counts round up; covers misaligned origins in both axes and a
  // rectangle that is both out of range and misaligned (range wins).
  task automatic test_block_formats();
    apply_setting(13, 7, 0, 6, FMT_BLK8, 32'h0000_1000, 1'b0);
    send_request(lock_req(1, 0, 1, 4, 4, 13, 7));
    send_request(lock_req(1, 0, 1, 1, 0, 4, 4));
    send_request(lock_req(1, 0, 1, 0, 2, 4, 4));
    send_request(lock_req(1, 0, 1, 1, 0, 20, 4));
    end_burst();
    write_reg(REG_PIXEL_FORMAT, FMT_BLK16);
    send_request(lock_req(4, 1, 1, 0, 0, 6, 3));
    end_burst();
    write_reg(REG_PIXEL_FORMAT, FMT_RESERVED);
    send_request(lock_req(5, 0, 1, 8, 4, 12, 7));
    end_burst();
  endtask

  // Out-of-range register values: zero and oversize dimensions, a level count
  // above the limit, face counts of seven and zero, and a write to an index
  // that has no register behind it.
  task automatic test_register_corners();
    write_reg(REG_TEX_WIDTH, 0);
    write_reg(REG_TEX_HEIGHT, 8191);
    write_reg(REG_MIP_LEVELS, 15);
    write_reg(REG_FACE_COUNT, 7);
    write_reg(REG_PIXEL_FORMAT, FMT_PIX32);
    write_reg(REG_STAGING_BASE, 32'h8000_0000);
    send_request(lock_req(5, 12, 1, 0, 0, 1, 1));
    send_request(lock_req(6, 0, 0, 0, 0, 0, 0));
    end_burst();
    write_reg(REG_FACE_COUNT, 0);
    send_request(lock_req(0, 0, 0, 0, 0, 0, 0));
    end_burst();
    write_reg(REG_TEX_HEIGHT, 1);
    write_reg(REG_MIP_LEVELS, 14);
    write_reg(REG_FACE_COUNT, 1);
    write_reg(REG_SPARE, $urandom());
    send_request(lock_req(0, 12, 0, 0, 0, 0, 0));
    end_burst();
  endtask

  // Random traffic over fourteen register settings. Sender idling cycles
  // through none, 61 and 36 percent; results can never be held off, so the
  // receiver side needs no stall model. Halfway through one setting the
  // sender stops until the block has answered everything.
  task automatic test_random_traffic();
    logic [DIM_W-1:0]  w, h;
    logic [LVL_W-1:0]  mips;
    logic [FACE_W-1:0] faces;
    logic [FMT_W-1:0]  fmt;
    logic [ADDR_W-1:0] base;
    int unsigned       idle_pct;
    for (int phase = 0; phase < 14; phase++) begin
      case (phase)
        0: begin
          w = 4096; h = 4096; mips = 0; faces = 6; fmt = FMT_BLK16; base = '1;
        end
        1: begin
          w = 1; h = 1; mips = 1; faces = 1; fmt = FMT_PIX32; base = '0;
        end
        2: begin
          w = 8191; h = 0; mips = 15; faces = 7; fmt = FMT_RESERVED; base = $urandom();
        end
        default: begin
          case ($urandom_range(0, 3))
            0: w = DIM_W'($urandom());
            1: w = DIM_W'($urandom_range(1, 4096));
            default: w = DIM_W'($urandom_range(1, 64));
          endcase
          case ($urandom_range(0, 3))
            0: h = DIM_W'($urandom());
            1: h = DIM_W'($urandom_range(1, 4096));
            default: h = DIM_W'($urandom_range(1, 64));
          endcase
          mips  = ($urandom_range(0, 2) == 0) ? LVL_W'(0) : LVL_W'($urandom());
          case ($urandom_range(0, 4))
            0, 1: faces = 6;
            2: faces = 1;
            default: faces = FACE_W'($urandom());
          endcase
          fmt  = FMT_W'($urandom());
          base = $urandom();
        end
      endcase
      apply_setting(w, h, mips, faces, fmt, base, phase >= 2);
      case (phase % 3)
        0: idle_pct = 0;
        1: idle_pct = 61;
        default: idle_pct = 36;
      endcase
      for (int n = 0; n < 125; n++) begin
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
          pause_requests($urandom_range(1, 6));
        send_request(random_request());
        if (phase == 5 && n == 60) end_burst();
      end
      end_burst();
    end
  endtask

  initial begin
    rst         <= 1'b1;
    start       <= 1'b0;
    face_index  <= '0;
    level_index <= '0;
    has_rect    <= 1'b0;
    rect_left   <= '0;
    rect_top    <= '0;
    rect_right  <= '0;
    rect_bottom <= '0;
    cfg_write   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // The block sweeps its level table after reset before it takes requests.
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);

    test_reset_defaults();
    test_pixel_limits();
    test_block_formats();
    test_register_corners();
    test_random_traffic();

    // Wait on so that any stray done pulse can still show up.
    repeat (10) @(posedge clk);
    $display("Checked %0d lock requests across %0d register writes.", items_sent,
             reg_writes);
    $display("Status mix: ok %0d, bad face/level %0d, bad rect %0d, misaligned %0d.",
             status_seen[ST_OK], status_seen[ST_BAD_SUB], status_seen[ST_BAD_RECT],
             status_seen[ST_MISALIGN]);
    if (error_count == 0 && expected_locks.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Watchdog: the whole run needs well under a tenth of this.
  initial begin
    #(5_000_000);
    $display("Timeout: %0d lock results still outstanding.", expected_locks.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
